/* rtl/drpi_pkg.sv */
package drpi_pkg;

    // Sine and cosine resolution: a full turn is cut into 2^TRIG_TABLE_BITS steps.
    localparam int TRIG_TABLE_BITS = 10;

    // Operand and product widths of the shared multiplier.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // One full turn in Q9.23 degrees.
    localparam logic [31:0] HEAD_FULL = 32'd3019898880;

    // Reset pose (1300 mm in Q20.12) and the default loop time (about 1 ms in Q0.24).
    localparam logic [31:0] POS_RESET = 32'd5324800;
    localparam logic [23:0] LT_RESET  = 24'd16777;

    // Odd Taylor coefficients of sin(pi/2 * x) in Q30.
    localparam logic [31:0] PC1 = 32'd1686629713;
    localparam logic [31:0] PC3 = 32'd693598668;
    localparam logic [31:0] PC5 = 32'd85569274;
    localparam logic [31:0] PC7 = 32'd5026992;
    localparam logic [31:0] PC9 = 32'd172271;

endpackage

/* rtl/drpi_mul.sv */
module drpi_mul (
    input  logic                                 i_clk,
    input  logic signed [drpi_pkg::MUL_W-1:0]    i_a,
    input  logic signed [drpi_pkg::MUL_W-1:0]    i_b,
    output logic signed [drpi_pkg::PROD_W-1:0]   o_prod
);
    import drpi_pkg::*;

    // Registered signed multiplier, one product per cycle.
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/dead_reckoning_pose_integrator_core.sv */
// The sequencer takes a new input word only while idle, once the result word of the previous
// word is loaded, and it holds before that load until the previous result word is taken.
// The single shared multiplier is used in turn for the heading step, the table index, both
// quarter-wave sines and the position products.
// Reset (synchronous, active low) clears the heading and tick count, puts x and y at 1300 mm
// and restores the default loop time.
module dead_reckoning_pose_integrator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: loop_time, unsigned Q0.24 seconds.
    input  logic         i_cfg_wr_en,
    input  logic [23:0]  i_cfg_wr_data,
    // Input words.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [23:0] linear_velocity, [47:24] angular_velocity
    input  logic [47:0]  i_s_axis_tdata,
    // Result words.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] heading, [127:96] tick_count
    output logic [127:0] o_m_axis_tdata
);
    import drpi_pkg::*;

    localparam int TB        = TRIG_TABLE_BITS;
    // The heading is scaled down by 2^SH before dividing by 360 to form the table index.
    localparam int SH        = 23 - TB;
    localparam int TW        = 33 - SH;
    // Division by 360 is a shift by 3 followed by a multiply with the rounded-up reciprocal
    // of 45 scaled by 2^RS. The shifted value stays below 2^(TB+6), so the error of the
    // reciprocal never reaches the next integer and the quotient is exact.
    localparam int RS        = TB + 12;

    localparam logic [32:0]  IDX_BIAS = 33'(180 << SH);
    localparam logic [MUL_W-1:0] RECIP_45 = MUL_W'(((64'd1 << RS) + 64'd44) / 64'd45);
    localparam logic [TB-2:0] QN      = {1'b1, {(TB-2){1'b0}}};
    localparam logic [TB:0]  IDX_MAX  = {1'b1, {TB{1'b0}}};

    localparam logic signed [PROD_W-1:0] STEP_MAX = PROD_W'(HEAD_FULL) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] STEP_MIN = -STEP_MAX;
    localparam logic signed [PROD_W-1:0] STEP_RND = PROD_W'(4096);
    localparam logic signed [PROD_W-1:0] SIN_RND  = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] SIN_MAX  = PROD_W'(32767);
    localparam logic signed [63:0]       POS_RND  = 64'h0000_0004_0000_0000;
    localparam logic signed [33:0]       HF34     = 34'(HEAD_FULL);
    localparam logic signed [32:0]       SAT_MAX  = 33'h0_7FFF_FFFF;
    localparam logic signed [32:0]       SAT_MIN  = 33'h1_8000_0000;

    // The sequencer issues one multiply per cycle in most states. The product returns in the next
    // cycle and is written back according to the state that issued it (r_prev).
    // The two sine evaluations (for r and for a quarter turn minus r) are interleaved so
    // that each dependent multiply finds its operand already written back.
    typedef enum logic [4:0] {
        S_IDLE,
        S_MH,    // angular velocity times loop time
        S_MV,    // linear velocity times loop time
        S_HW,    // heading update and wrap
        S_IDX,   // scale heading and multiply by the reciprocal of 45
        S_DIV,   // the quotient product returns
        S_KSET,  // quadrant and the two quarter-wave arguments
        S_X2A, S_X2B,
        S_P9A, S_P9B,
        S_P7A, S_P7B,
        S_P5A, S_P5B,
        S_P3A, S_P3B,
        S_SA,  S_SB,
        S_SWB,   // write back the second sine
        S_CH, S_CL, S_SH, S_SL,
        S_PWB,   // write back the last partial product
        S_POS    // saturating position update and result load
    } t_state;

    t_state r_state;
    t_state r_prev;

    logic [23:0]        r_loop_time;
    logic signed [23:0] r_v;
    logic signed [23:0] r_w;
    logic [31:0]        r_heading;
    logic [31:0]        r_tick;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [33:0] r_step;
    logic signed [23:0] r_vhi;
    logic [23:0]        r_vlo;
    logic [TB:0]        r_q;
    logic [1:0]         r_quad;
    logic [30:0]        r_xa;
    logic [30:0]        r_xb;
    logic [30:0]        r_x2a;
    logic [30:0]        r_x2b;
    logic signed [MUL_W-1:0] r_pa;
    logic signed [MUL_W-1:0] r_pb;
    logic [14:0]        r_sa;
    logic [14:0]        r_sb;
    logic signed [63:0] r_acc_x;
    logic signed [63:0] r_acc_y;
    logic               r_m_valid;
    logic [127:0]       r_m_data;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;

    logic signed [PROD_W-1:0] step_raw;
    logic signed [33:0]       n_step;
    logic signed [33:0]       head_sum;
    logic [31:0]              n_heading;
    logic [32:0]              idx_sum;
    logic [TW-1:0]            idx_t;
    logic [TB-2:0]            k_a;
    logic [TB-2:0]            k_b;
    logic signed [16:0]       sa_s;
    logic signed [16:0]       sb_s;
    logic signed [16:0]       cos_v;
    logic signed [16:0]       sin_v;
    logic signed [31:0]       n_x;
    logic signed [31:0]       n_y;
    logic                     pos_fire;

    // Horner step: next coefficient minus the product brought back to Q30.
    function automatic logic signed [MUL_W-1:0] poly_step(
        input logic signed [PROD_W-1:0] prod,
        input logic signed [PROD_W-1:0] coef
    );
        logic signed [PROD_W-1:0] diff;
        begin
            diff = coef - (prod >>> 30);
            return diff[MUL_W-1:0];
        end
    endfunction

    // Final sine product to Q1.15, rounded and held within 0 to 32767.
    function automatic logic [14:0] sine_round(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] t;
        begin
            t = ((prod >>> 30) + SIN_RND) >>> 15;
            if (t > SIN_MAX) begin
                t = SIN_MAX;
            end else if (t < 0) begin
                t = '0;
            end
            return t[14:0];
        end
    endfunction

    // Position step rounded from Q.47 to Q.12 and added with saturation.
    function automatic logic signed [31:0] pos_update(
        input logic signed [31:0] pos,
        input logic signed [63:0] acc
    );
        logic signed [63:0] delta;
        logic signed [32:0] sum;
        begin
            delta = (acc + POS_RND) >>> 35;
            sum   = 33'(pos) + signed'(delta[32:0]);
            if (sum > SAT_MAX) begin
                sum = SAT_MAX;
            end else if (sum < SAT_MIN) begin
                sum = SAT_MIN;
            end
            return sum[31:0];
        end
    endfunction

    drpi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MH: begin
                mul_a = MUL_W'(r_w);
                mul_b = signed'(MUL_W'(r_loop_time));
            end
            S_MV: begin
                mul_a = MUL_W'(r_v);
                mul_b = signed'(MUL_W'(r_loop_time));
            end
            S_IDX: begin
                mul_a = signed'(MUL_W'(idx_t[TW-1:3]));
                mul_b = signed'(RECIP_45);
            end
            S_X2A: begin
                mul_a = signed'(MUL_W'(r_xa));
                mul_b = signed'(MUL_W'(r_xa));
            end
            S_X2B: begin
                mul_a = signed'(MUL_W'(r_xb));
                mul_b = signed'(MUL_W'(r_xb));
            end
            S_P9A: begin
                mul_a = signed'(MUL_W'(PC9));
                mul_b = signed'(MUL_W'(r_x2a));
            end
            S_P9B: begin
                mul_a = signed'(MUL_W'(PC9));
                mul_b = signed'(MUL_W'(r_x2b));
            end
            S_P7A, S_P5A, S_P3A: begin
                mul_a = r_pa;
                mul_b = signed'(MUL_W'(r_x2a));
            end
            S_P7B, S_P5B, S_P3B: begin
                mul_a = r_pb;
                mul_b = signed'(MUL_W'(r_x2b));
            end
            S_SA: begin
                mul_a = r_pa;
                mul_b = signed'(MUL_W'(r_xa));
            end
            S_SB: begin
                mul_a = r_pb;
                mul_b = signed'(MUL_W'(r_xb));
            end
            S_CH: begin
                mul_a = MUL_W'(r_vhi);
                mul_b = MUL_W'(cos_v);
            end
            S_CL: begin
                mul_a = signed'(MUL_W'(r_vlo));
                mul_b = MUL_W'(cos_v);
            end
            S_SH: begin
                mul_a = MUL_W'(r_vhi);
                mul_b = MUL_W'(sin_v);
            end
            S_SL: begin
                mul_a = signed'(MUL_W'(r_vlo));
                mul_b = MUL_W'(sin_v);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Heading step: round the Q.36 product to Q.23, then clamp below a full turn so
    // that one wrap always brings the heading back into range.
    always_comb begin
        step_raw = (mul_prod + STEP_RND) >>> 13;
        if (step_raw > STEP_MAX) begin
            step_raw = STEP_MAX;
        end else if (step_raw < STEP_MIN) begin
            step_raw = STEP_MIN;
        end
        n_step = step_raw[33:0];
    end

    always_comb begin
        head_sum = signed'({2'b00, r_heading}) + r_step;
        if (head_sum >= HF34) begin
            head_sum = head_sum - HF34;
        end else if (head_sum < 0) begin
            head_sum = head_sum + HF34;
        end
        n_heading = head_sum[31:0];
    end

    // Table index is round(heading * 2^TB / full turn). Dropping the low SH bits after
    // adding half a step leaves an exact divide by 360.
    assign idx_sum = {1'b0, r_heading} + IDX_BIAS;
    assign idx_t   = idx_sum[32:SH];

    assign k_a = {1'b0, r_q[TB-3:0]};
    assign k_b = QN - k_a;

    // Fold the two quarter-wave values over the four quadrants.
    assign sa_s = signed'({2'b00, r_sa});
    assign sb_s = signed'({2'b00, r_sb});

    always_comb begin
        case (r_quad)
            2'd0: begin
                sin_v = sa_s;
                cos_v = sb_s;
            end
            2'd1: begin
                sin_v = sb_s;
                cos_v = -sa_s;
            end
            2'd2: begin
                sin_v = -sa_s;
                cos_v = -sb_s;
            end
            default: begin
                sin_v = -sb_s;
                cos_v = sa_s;
            end
        endcase
    end

    assign n_x = pos_update(r_x, r_acc_x);
    assign n_y = pos_update(r_y, r_acc_y);

    // The result register may load when it is empty or being drained this cycle.
    assign pos_fire = (r_state == S_POS) && (!r_m_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= S_IDLE;
            r_loop_time <= LT_RESET;
            r_heading   <= '0;
            r_tick      <= '0;
            r_x         <= POS_RESET;
            r_y         <= POS_RESET;
            r_m_valid   <= 1'b0;
        end else begin
            r_prev <= r_state;

            if (i_cfg_wr_en) begin
                r_loop_time <= i_cfg_wr_data;
            end

            // A new result word replaces the one being drained in the same cycle.
            if (pos_fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            // Write back the product issued in the previous cycle.
            case (r_prev)
                S_MH:  r_step  <= n_step;
                S_MV: begin
                    r_vhi <= mul_prod[47:24];
                    r_vlo <= mul_prod[23:0];
                end
                S_IDX: r_q     <= mul_prod[RS+TB:RS];
                S_X2A: r_x2a   <= mul_prod[60:30];
                S_X2B: r_x2b   <= mul_prod[60:30];
                S_P9A: r_pa    <= poly_step(mul_prod, PROD_W'(PC7));
                S_P9B: r_pb    <= poly_step(mul_prod, PROD_W'(PC7));
                S_P7A: r_pa    <= poly_step(mul_prod, PROD_W'(PC5));
                S_P7B: r_pb    <= poly_step(mul_prod, PROD_W'(PC5));
                S_P5A: r_pa    <= poly_step(mul_prod, PROD_W'(PC3));
                S_P5B: r_pb    <= poly_step(mul_prod, PROD_W'(PC3));
                S_P3A: r_pa    <= poly_step(mul_prod, PROD_W'(PC1));
                S_P3B: r_pb    <= poly_step(mul_prod, PROD_W'(PC1));
                S_SA:  r_sa    <= sine_round(mul_prod);
                S_SB:  r_sb    <= sine_round(mul_prod);
                S_CH:  r_acc_x <= 64'(mul_prod <<< 24);
                S_CL:  r_acc_x <= r_acc_x + 64'(mul_prod);
                S_SH:  r_acc_y <= 64'(mul_prod <<< 24);
                S_SL:  r_acc_y <= r_acc_y + 64'(mul_prod);
                default: begin
                end
            endcase

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_v     <= i_s_axis_tdata[23:0];
                        r_w     <= i_s_axis_tdata[47:24];
                        r_state <= S_MH;
                    end
                end
                S_MH: r_state <= S_MV;
                S_MV: r_state <= S_HW;
                S_HW: begin
                    r_heading <= n_heading;
                    r_tick    <= r_tick + 32'd1;
                    r_state   <= S_IDX;
                end
                S_IDX: r_state <= S_DIV;
                S_DIV: r_state <= S_KSET;
                S_KSET: begin
                    r_quad  <= r_q[TB-1:TB-2];
                    r_xa    <= {k_a, {(32-TB){1'b0}}};
                    r_xb    <= {k_b, {(32-TB){1'b0}}};
                    r_state <= S_X2A;
                end
                S_X2A: r_state <= S_X2B;
                S_X2B: r_state <= S_P9A;
                S_P9A: r_state <= S_P9B;
                S_P9B: r_state <= S_P7A;
                S_P7A: r_state <= S_P7B;
                S_P7B: r_state <= S_P5A;
                S_P5A: r_state <= S_P5B;
                S_P5B: r_state <= S_P3A;
                S_P3A: r_state <= S_P3B;
                S_P3B: r_state <= S_SA;
                S_SA:  r_state <= S_SB;
                S_SB:  r_state <= S_SWB;
                S_SWB: r_state <= S_CH;
                S_CH:  r_state <= S_CL;
                S_CL:  r_state <= S_SH;
                S_SH:  r_state <= S_SL;
                S_SL:  r_state <= S_PWB;
                S_PWB: r_state <= S_POS;
                S_POS: begin
                    if (pos_fire) begin
                        r_x       <= n_x;
                        r_y       <= n_y;
                        r_m_data  <= {r_tick, r_heading, n_y, n_x};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // The heading wrap must keep the heading below one full turn.
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading < HEAD_FULL)
        else $error("heading left the range of one turn");

    // A result word that is not taken stays up and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result word dropped or changed while waiting");

    // The rounded table index never exceeds one full turn of steps.
    a_idx_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KSET) |-> (r_q <= IDX_MAX))
        else $error("table index quotient out of range");

    // A new result word only appears out of the position update state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_POS))
        else $error("result word raised outside the position update");

endmodule

/* tb/sv/dead_reckoning_pose_integrator_core_test.sv */
`timescale 1ns / 100ps

module dead_reckoning_pose_integrator_core_test;

    import drpi_pkg::TRIG_TABLE_BITS;

    // Turn and pose constants, kept here so that the expected values lean on the package only
    // for the table size. A full turn is 360 degrees in Q9.23.
    localparam longint FULL_TURN  = 64'd3019898880;
    localparam int     START_POS  = 5324800;   // 1300 mm in Q20.12
    localparam logic [23:0] DEFAULT_LOOP_TIME = 24'd16777;

    // Odd Taylor coefficients of sin(pi/2 * x) in Q30.
    localparam longint SIN_C1 = 64'd1686629713;
    localparam longint SIN_C3 = 64'd693598668;
    localparam longint SIN_C5 = 64'd85569274;
    localparam longint SIN_C7 = 64'd5026992;
    localparam longint SIN_C9 = 64'd172271;

    // Extremes of the 24-bit velocity fields and a turn rate of about 90 degrees per second.
    localparam logic signed [23:0] FIELD_MAX    = 24'sh7FFFFF;
    localparam logic signed [23:0] FIELD_MIN    = 24'sh800000;
    localparam logic signed [23:0] QUARTER_RATE = 24'sd368640;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AFTER  = 150;   // results checked before the long receiver hold-off
    localparam int HOLD_CYCLES = 300;

    // One input word: linear velocity in the low bits, angular velocity above it.
    typedef struct packed {
        logic signed [23:0] ang;
        logic signed [23:0] lin;
    } tick_word_t;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [31:0] ticks;
    } pose_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [23:0]  cfg_wr_data = '0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [47:0]  s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [127:0] m_data;

    dead_reckoning_pose_integrator_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mirror of the block's state, advanced once for every word the block accepts.
    logic [23:0] pose_loop_time = DEFAULT_LOOP_TIME;
    logic [31:0] pose_heading = '0;
    int          pose_x = START_POS;
    int          pose_y = START_POS;
    logic [31:0] pose_ticks = '0;

    tick_word_t pending_ticks[$];
    pose_t      expected_poses[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int cycle_count = 0;

    // Sine of a quarter-wave table step, k in 0 .. 2^(TRIG_TABLE_BITS-2), as Q1.15.
    // The polynomial runs in Q30 and every intermediate product fits in 64 bits.
    function automatic longint quarter_wave(input longint k);
        longint x;
        longint x2;
        longint p;
        longint s;
        x  = k <<< (30 - (TRIG_TABLE_BITS - 2));
        x2 = (x * x) >>> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((p * x2) >>> 30);
        p  = SIN_C5 - ((p * x2) >>> 30);
        p  = SIN_C3 - ((p * x2) >>> 30);
        p  = SIN_C1 - ((p * x2) >>> 30);
        s  = (p * x) >>> 30;
        s  = (s + (64'sd1 <<< 14)) >>> 15;
        if (s > 32767)
            s = 32767;
        if (s < 0)
            s = 0;
        return s;
    endfunction

    function automatic int saturating_add(input int base, input longint delta);
        longint sum;
        sum = longint'(base) + delta;
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return int'(sum);
    endfunction

    // Integrates one tick into the mirrored pose and returns the word the block must send.
    // The arithmetic shifts on signed values are floor divisions, which is what the
    // rounding of the block asks for.
    function automatic pose_t advance_pose(input logic signed [23:0] lin,
                                           input logic signed [23:0] ang);
        longint v;
        longint w;
        longint lt;
        longint step;
        longint h;
        longint unsigned idx;
        longint quad;
        longint r;
        longint quarter_steps;
        longint sa;
        longint sb;
        longint c;
        longint s;
        pose_t  res;
        v  = lin;
        w  = ang;
        lt = longint'(pose_loop_time);
        pose_ticks = pose_ticks + 32'd1;

        // The heading step is clamped just short of a full turn so that one wrap is enough.
        step = (w * lt + (64'sd1 <<< 12)) >>> 13;
        if (step > FULL_TURN - 1)
            step = FULL_TURN - 1;
        if (step < -(FULL_TURN - 1))
            step = -(FULL_TURN - 1);
        h = longint'(pose_heading) + step;
        if (h >= FULL_TURN)
            h = h - FULL_TURN;
        else if (h < 0)
            h = h + FULL_TURN;
        pose_heading = h[31:0];

        // Nearest table step of the new heading, then the quadrant folding.
        idx = ((longint'(pose_heading) << TRIG_TABLE_BITS) + FULL_TURN / 2) / FULL_TURN;
        idx = idx & ((64'd1 << TRIG_TABLE_BITS) - 1);
        quarter_steps = 64'sd1 <<< (TRIG_TABLE_BITS - 2);
        quad = longint'(idx >> (TRIG_TABLE_BITS - 2));
        r    = longint'(idx) & (quarter_steps - 1);
        sa   = quarter_wave(r);
        sb   = quarter_wave(quarter_steps - r);
        case (quad)
            0: begin s = sa;  c = sb;  end
            1: begin s = sb;  c = -sa; end
            2: begin s = -sa; c = -sb; end
            default: begin s = -sb; c = sa; end
        endcase

        pose_x = saturating_add(pose_x, (v * c * lt + (64'sd1 <<< 34)) >>> 35);
        pose_y = saturating_add(pose_y, (v * s * lt + (64'sd1 <<< 34)) >>> 35);

        res.pos_x   = pose_x;
        res.pos_y   = pose_y;
        res.heading = pose_heading;
        res.ticks   = pose_ticks;
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Driver. Words leave the pending queue in bursts of random length separated by random
    // gaps; about half the bursts run straight into the next one, so there are stretches
    // without any idling too. The expectation is computed at the edge where the block takes
    // the word, so it always sees the loop time that the block itself uses.
    // ------------------------------------------------------------------------------------
    int         gap_left = 0;
    int         burst_left = 1;
    tick_word_t next_word;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (s_valid && s_ready) begin
                expected_poses.push_back(advance_pose(s_data[23:0], s_data[47:24]));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    next_word  = pending_ticks.pop_front();
                    s_valid    <= 1'b1;
                    s_data     <= next_word;
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor. The receiver picks a new busy level whenever rx_slot wraps, from never stalling to
    // stalling most of the time. Once, after a fixed number of results, it holds off for a
    // long stretch while the driver keeps offering words, so the block backs up and has to
    // stall its input.
    // ------------------------------------------------------------------------------------
    int    rx_busy_pct = 0;
    int    rx_slot = 0;
    int    rx_hold = 0;
    bit    rx_hold_done = 1'b0;
    pose_t want;

    function automatic void check_field(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                   field, exp_val, exp_val, act_val, act_val);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    $error("result word with no tick waiting for it: 0x%032h", m_data);
                    n_errors++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("pos_x", want.pos_x, m_data[31:0]);
                    check_field("pos_y", want.pos_y, m_data[63:32]);
                    check_field("heading", want.heading, m_data[95:64]);
                    check_field("tick_count", want.ticks, m_data[127:96]);
                end
                n_checked++;
                if (n_checked == HOLD_AFTER && !rx_hold_done) begin
                    rx_hold      = HOLD_CYCLES;
                    rx_hold_done = 1'b1;
                end
            end
            if (rx_hold > 0)
                rx_hold = rx_hold - 1;
            if (rx_slot == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_busy_pct = 0;
                    1: rx_busy_pct = 30;
                    2: rx_busy_pct = 60;
                    default: rx_busy_pct = 85;
                endcase
            end
            rx_slot = (rx_slot + 1) % 64;
            m_ready <= (rx_hold == 0) && ($urandom_range(0, 99) >= rx_busy_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------------------
    task automatic queue_tick(input logic signed [23:0] lin, input logic signed [23:0] ang);
        tick_word_t w;
        w.lin = lin;
        w.ang = ang;
        pending_ticks.push_back(w);
        n_queued++;
    endtask

    // A velocity with the extremes and the values around zero weighted up.
    function automatic logic signed [23:0] pick_velocity();
        case ($urandom_range(0, 7))
            0: return FIELD_MAX;
            1: return FIELD_MIN;
            2: return 24'(int'($urandom_range(0, 2)) - 1);
            default: return 24'($urandom);
        endcase
    endfunction

    // Most of the random words come in cruise runs: one speed held for many ticks with a
    // gentle or no turn, which is what drives x and y into saturation and walks the heading
    // through every quadrant. The rest are words with both fields random.
    task automatic queue_random(input int n_ticks);
        int left;
        int run_len;
        logic signed [23:0] cruise_lin;
        logic signed [23:0] cruise_ang;
        left = n_ticks;
        while (left > 0) begin
            if ($urandom_range(0, 2) != 0) begin
                run_len = $urandom_range(4, 24);
                if ($urandom_range(0, 1) == 0)
                    cruise_lin = ($urandom_range(0, 1) == 0) ? FIELD_MAX : FIELD_MIN;
                else
                    cruise_lin = pick_velocity();
                if ($urandom_range(0, 1) == 0)
                    cruise_ang = '0;
                else
                    cruise_ang = 24'(int'($urandom_range(0, 8192)) - 4096);
                for (int k = 0; k < run_len && left > 0; k++) begin
                    queue_tick(cruise_lin, cruise_ang);
                    left--;
                end
            end else begin
                queue_tick(pick_velocity(), pick_velocity());
                left--;
            end
        end
    endtask

    // Waits until every queued word has been taken and every expected result has come back.
    // The counters are checked at clock edges, so whichever order the processes of one edge
    // run in, the loop at worst goes round once more.
    task automatic drain();
        while (n_accepted != n_queued || expected_poses.size() != 0)
            @(posedge clk);
    endtask

    // The loop time is only rewritten while the block is idle. Every tick yields a result,
    // so an empty expectation queue means the block has nothing left in flight.
    task automatic set_loop_time(input logic [23:0] value);
        drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        pose_loop_time = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Default loop time after reset: field extremes, every sign combination, and the
        // smallest nonzero speeds. Full negative turn rate wraps the heading below zero.
        queue_tick('0, '0);
        queue_tick(FIELD_MAX, '0);
        queue_tick(FIELD_MIN, '0);
        queue_tick('0, FIELD_MAX);
        queue_tick('0, FIELD_MIN);
        queue_tick(FIELD_MAX, FIELD_MAX);
        queue_tick(FIELD_MIN, FIELD_MIN);
        queue_tick(FIELD_MAX, FIELD_MIN);
        queue_tick(FIELD_MIN, FIELD_MAX);
        queue_tick(24'sd1, 24'sd1);
        queue_tick(-24'sd1, -24'sd1);
        queue_random(60);

        // Longest loop time: a full-scale turn rate hits the heading step clamp in both
        // directions, and quarter-turn steps move the pose into the other quadrants.
        set_loop_time(24'hFFFFFF);
        queue_tick('0, FIELD_MAX);
        queue_tick('0, FIELD_MIN);
        queue_tick(FIELD_MAX, QUARTER_RATE);
        queue_tick(FIELD_MIN, -QUARTER_RATE);
        queue_random(150);

        // Zero loop time: the pose and heading must hold while the tick count goes on.
        set_loop_time('0);
        queue_tick(FIELD_MAX, FIELD_MAX);
        queue_tick(FIELD_MIN, FIELD_MIN);
        queue_random(20);

        set_loop_time(24'd1);
        queue_random(20);

        set_loop_time(24'($urandom_range(32'h10000, 32'h3FFFFF)));
        queue_random(100);

        set_loop_time(24'h800000);
        queue_random(100);

        drain();
        repeat (TRIG_TABLE_BITS + 30) @(posedge clk);
        if (n_errors == 0 && expected_poses.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
